// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the particle collision step
// Payload structs of both channels, the table entry layout, operation and
// register codes, and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_SCREEN_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_PARTICLE_COUNT = 2'd2;

  localparam logic [11:0] SCREEN_WIDTH_RST  = 12'd1000;
  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd700;

  // Stand-in distance of 0.01 in Q16.16 for coincident centers.
  localparam logic [25:0] MIN_DIST = 26'd655;

  typedef struct packed {
    logic [1:0]         operation;
    logic [4:0]         entry_index;
    logic signed [31:0] in_pos_x;
    logic signed [31:0] in_pos_y;
    logic signed [31:0] in_vel_x;
    logic signed [31:0] in_vel_y;
    logic [3:0]         in_scale;
    logic signed [31:0] in_life;
    logic [15:0]        tick_time;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         out_index;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_life;
    logic               alive;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [3:0]         scale;
    logic signed [31:0] life;
  } entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/particle_collision_step.sv =====
// ----------------------------------------------------------------------------
// particle_collision_step: table of circular particles with elastic collisions
// Holds position, velocity, scale and life of each particle in one on-chip
// table, loads and reads single entries, and on a tick moves every live
// particle, bounces it off the screen edges and resolves all pairwise
// overlaps before streaming out every entry in use.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                          | Handshake
//  ---------+--------------------------------+--------------------------------
//  input    | start, busy, in_data           | beat taken when start && !busy
//  result   | out_valid, out_data            | one-cycle strobe, no back-pressure
//  config   | cfg_we, cfg_index, cfg_wdata   | written on any edge with cfg_we
//
// A read beat's entry passes the read register, then the result register; a
// read beyond the table loads the result register directly. A tick moves each
// live entry (read, two multiplies, write-back), then takes each pair: a pair
// that is clearly apart is only read and compared, a pair close enough to need
// the distance runs a 26-step square root and two 41-step divisions. All
// multiplications share one multiply-accumulate unit. The emit pass reads each
// entry, then sends it. The whole table sits in one memory with a single read
// port and a single write port.
// Reset is synchronous and active low; it clears the control state and the
// configuration registers, not the table. The result receiver cannot stall.
// ----------------------------------------------------------------------------
module particle_collision_step #(
  parameter int MAX_PARTICLES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  pcs_pkg::in_item_t   in_data,
  output logic                busy,
  output logic                out_valid,
  output pcs_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_wdata
);
  import pcs_pkg::*;

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  typedef enum logic [21:0] {
    S_IDLE    = 22'h000001,
    S_RD_EMIT = 22'h000002,
    S_MV_RD   = 22'h000004,
    S_MV_LD   = 22'h000008,
    S_MV_MX   = 22'h000010,
    S_MV_MY   = 22'h000020,
    S_MV_WR   = 22'h000040,
    S_CP_RDI  = 22'h000080,
    S_CP_RDJ  = 22'h000100,
    S_CP_LD   = 22'h000200,
    S_CP_RR   = 22'h000400,
    S_CP_SQX  = 22'h000800,
    S_CP_SQY  = 22'h001000,
    S_CP_CMP  = 22'h002000,
    S_CP_SQRT = 22'h004000,
    S_CP_DIVX = 22'h008000,
    S_CP_DIVY = 22'h010000,
    S_CP_MAC  = 22'h020000,
    S_CP_WRI  = 22'h040000,
    S_CP_WRJ  = 22'h080000,
    S_EM_RD   = 22'h100000,
    S_EM_OUT  = 22'h200000
  } state_t;

  // Particle table: one synchronous memory, one read and one write port.
  entry_t mem [MAX_PARTICLES];

  state_t state_r, state_nxt;
  logic [11:0] cfg_w_r, cfg_h_r;
  logic [5:0]  cfg_cnt_r;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, n_r, n_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  entry_t rdata_r, ei_r, ei_nxt, ej_r, ej_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [26:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [24:0] rq_r, rq_nxt;
  logic [51:0] rr_r, rr_nxt, sq_r, sq_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic [25:0] root_r, root_nxt, dist_r, dist_nxt, drem_r, drem_nxt;
  logic [40:0] dvd_r, dvd_nxt;
  logic signed [19:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic signed [27:0] push_x_r, push_x_nxt, push_y_r, push_y_nxt;
  logic signed [37:0] v1t_r, v1t_nxt, v2t_r, v2t_nxt, v1n_r, v1n_nxt, v2n_r, v2n_nxt;
  logic signed [31:0] nv1x_r, nv1x_nxt, nv1y_r, nv1y_nxt;
  logic signed [31:0] nv2x_r, nv2x_nxt, nv2y_r, nv2y_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // Memory port controls.
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  entry_t        mem_wd;

  // Shared multiply-accumulate unit.
  logic signed [37:0] mac_a;
  logic signed [26:0] mac_b;
  logic               mac_clr;
  logic signed [64:0] prod;
  logic signed [65:0] acc_sum;

  // Datapath helpers.
  logic signed [19:0] tx;
  logic signed [26:0] ov;
  logic signed [32:0] dx33, dy33;
  logic [32:0]        dx_mag, dy_mag;
  logic [24:0]        rq_w, dxm, dym;
  logic [29:0]        sq_rem_sh;
  logic [27:0]        sq_trial;
  logic               sq_ge;
  logic [26:0]        dv_rem_sh;
  logic               dv_ge;
  logic [40:0]        dv_q;
  logic signed [31:0] mv_py, mv_life;
  logic               next_pair, next_move;
  logic               idx_ok;

  assign prod    = mac_a * mac_b;
  assign acc_sum = (mac_clr ? 66'sd0 : acc_r) + 66'(prod);
  assign tx      = -ny_r;
  assign ov      = $signed({2'b00, rq_r}) - $signed({1'b0, dist_r});
  assign dxm     = 25'(dx_r[26] ? -dx_r : dx_r);
  assign dym     = 25'(dy_r[26] ? -dy_r : dy_r);
  assign idx_ok  = 32'(in_data.entry_index) < MAX_PARTICLES;

  // Square root step: two radicand bits per cycle, one root bit out.
  assign sq_rem_sh = {rem_r, sq_r[51:50]};
  assign sq_trial  = {root_r, 2'b01};
  assign sq_ge     = sq_rem_sh >= 30'(sq_trial);

  // Restoring division step: one quotient bit per cycle.
  assign dv_rem_sh = {drem_r, dvd_r[40]};
  assign dv_ge     = dv_rem_sh >= {1'b0, dist_r};
  assign dv_q      = {dvd_r[39:0], dv_ge};

  // Center offsets of the pair; the second entry is still on the read port.
  assign dx33   = $signed({ei_r.pos_x[31], ei_r.pos_x}) -
                  $signed({rdata_r.pos_x[31], rdata_r.pos_x});
  assign dy33   = $signed({ei_r.pos_y[31], ei_r.pos_y}) -
                  $signed({rdata_r.pos_y[31], rdata_r.pos_y});
  assign dx_mag = dx33[32] ? 33'(-dx33) : 33'(dx33);
  assign dy_mag = dy33[32] ? 33'(-dy33) : 33'(dy33);
  assign rq_w   = {5'(ei_r.scale) + 5'(rdata_r.scale), 20'b0};

  // Multiplier operand selection.
  always_comb begin
    mac_a   = '0;
    mac_b   = '0;
    mac_clr = 1'b1;
    unique case (state_r)
      S_MV_MX: begin
        mac_a = 38'(ei_r.vel_x);
        mac_b = $signed({11'b0, dt_r});
      end
      S_MV_MY: begin
        mac_a = 38'(ei_r.vel_y);
        mac_b = $signed({11'b0, dt_r});
      end
      S_CP_RR: begin
        mac_a = $signed({13'b0, rq_r});
        mac_b = $signed({2'b0, rq_r});
      end
      S_CP_SQX: begin
        mac_a = 38'(dx_r);
        mac_b = dx_r;
      end
      S_CP_SQY: begin
        mac_a   = 38'(dy_r);
        mac_b   = dy_r;
        mac_clr = 1'b0;
      end
      S_CP_MAC: begin
        case (cnt_r)
          6'd0:  begin mac_a = 38'(nx_r);       mac_b = ov;          end
          6'd1:  begin mac_a = 38'(ny_r);       mac_b = ov;          end
          6'd2:  begin mac_a = 38'(ei_r.vel_x); mac_b = 27'(tx);     end
          6'd3:  begin mac_a = 38'(ei_r.vel_y); mac_b = 27'(nx_r); mac_clr = 1'b0; end
          6'd4:  begin mac_a = 38'(ej_r.vel_x); mac_b = 27'(tx);     end
          6'd5:  begin mac_a = 38'(ej_r.vel_y); mac_b = 27'(nx_r); mac_clr = 1'b0; end
          6'd6:  begin mac_a = 38'(ei_r.vel_x); mac_b = 27'(nx_r);   end
          6'd7:  begin mac_a = 38'(ei_r.vel_y); mac_b = 27'(ny_r); mac_clr = 1'b0; end
          6'd8:  begin mac_a = 38'(ej_r.vel_x); mac_b = 27'(nx_r);   end
          6'd9:  begin mac_a = 38'(ej_r.vel_y); mac_b = 27'(ny_r); mac_clr = 1'b0; end
          6'd10: begin mac_a = v1n_r;           mac_b = 27'(nx_r);   end
          6'd11: begin mac_a = v2t_r;           mac_b = 27'(tx);   mac_clr = 1'b0; end
          6'd12: begin mac_a = v1n_r;           mac_b = 27'(ny_r);   end
          6'd13: begin mac_a = v2t_r;           mac_b = 27'(nx_r); mac_clr = 1'b0; end
          6'd14: begin mac_a = v2n_r;           mac_b = 27'(nx_r);   end
          6'd15: begin mac_a = v1t_r;           mac_b = 27'(tx);   mac_clr = 1'b0; end
          6'd16: begin mac_a = v2n_r;           mac_b = 27'(ny_r);   end
          6'd17: begin mac_a = v1t_r;           mac_b = 27'(nx_r); mac_clr = 1'b0; end
          default: begin mac_a = '0;            mac_b = '0;          end
        endcase
      end
      default: begin
        mac_a = '0;
      end
    endcase
  end

  // Move results for the y axis and life, needed in the write-back cycle.
  assign mv_py   = sat32(66'(ei_r.pos_y) + (acc_r >>> 16));
  assign mv_life = sat32(66'(ei_r.life) - $signed({50'b0, dt_r}));

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    n_nxt         = n_r;
    dt_nxt        = dt_r;
    cnt_nxt       = cnt_r;
    ei_nxt        = ei_r;
    ej_nxt        = ej_r;
    acc_nxt       = acc_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    rq_nxt        = rq_r;
    rr_nxt        = rr_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    dist_nxt      = dist_r;
    drem_nxt      = drem_r;
    dvd_nxt       = dvd_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    push_x_nxt    = push_x_r;
    push_y_nxt    = push_y_r;
    v1t_nxt       = v1t_r;
    v2t_nxt       = v2t_r;
    v1n_nxt       = v1n_r;
    v2n_nxt       = v2n_r;
    nv1x_nxt      = nv1x_r;
    nv1y_nxt      = nv1y_r;
    nv2x_nxt      = nv2x_r;
    nv2y_nxt      = nv2y_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = i_r[IW-1:0];
    mem_ra        = i_r[IW-1:0];
    mem_wd        = ei_r;
    next_pair     = 1'b0;
    next_move     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        mem_ra = IW'(in_data.entry_index);
        mem_wa = IW'(in_data.entry_index);
        mem_wd = '{pos_x: in_data.in_pos_x, pos_y: in_data.in_pos_y,
                   vel_x: in_data.in_vel_x, vel_y: in_data.in_vel_y,
                   scale: in_data.in_scale, life: in_data.in_life};
        if (start) begin
          case (in_data.operation)
            OP_WRITE: begin
              mem_we = idx_ok;
            end
            OP_READ: begin
              if (idx_ok) begin
                i_nxt     = CW'(in_data.entry_index);
                state_nxt = S_RD_EMIT;
              end else begin
                // A read beyond the table returns an empty record.
                out_valid_nxt = 1'b1;
                out_nxt       = '0;
                out_nxt.out_index = in_data.entry_index;
                out_nxt.last      = 1'b1;
              end
            end
            OP_TICK: begin
              dt_nxt = in_data.tick_time;
              n_nxt  = (32'(cfg_cnt_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES)
                                                         : CW'(cfg_cnt_r);
              i_nxt  = '0;
              if (cfg_cnt_r != 6'd0) begin
                state_nxt = S_MV_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_RD_EMIT: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{out_index: 5'(i_r), out_pos_x: rdata_r.pos_x,
                    out_pos_y: rdata_r.pos_y, out_vel_x: rdata_r.vel_x,
                    out_vel_y: rdata_r.vel_y, out_life: rdata_r.life,
                    alive: rdata_r.life > 32'sd0, last: 1'b1};
        state_nxt = S_IDLE;
      end

      S_MV_RD: begin
        state_nxt = S_MV_LD;
      end

      S_MV_LD: begin
        ei_nxt = rdata_r;
        if (rdata_r.life > 32'sd0) begin
          state_nxt = S_MV_MX;
        end else begin
          next_move = 1'b1;
        end
      end

      S_MV_MX: begin
        acc_nxt   = acc_sum;
        state_nxt = S_MV_MY;
      end

      S_MV_MY: begin
        ei_nxt.pos_x = sat32(66'(ei_r.pos_x) + (acc_r >>> 16));
        acc_nxt      = acc_sum;
        state_nxt    = S_MV_WR;
      end

      S_MV_WR: begin
        mem_we       = 1'b1;
        mem_wd       = ei_r;
        mem_wd.pos_y = mv_py;
        mem_wd.life  = mv_life;
        // A particle past a wall turns its velocity component around.
        if (ei_r.pos_x < 32'sd0 ||
            $signed({ei_r.pos_x[31], ei_r.pos_x}) > $signed({5'b0, cfg_w_r, 16'b0})) begin
          mem_wd.vel_x = (ei_r.vel_x == 32'sh80000000) ? 32'sh7fffffff : -ei_r.vel_x;
        end
        if (mv_py < 32'sd0 ||
            $signed({mv_py[31], mv_py}) > $signed({5'b0, cfg_h_r, 16'b0})) begin
          mem_wd.vel_y = (ei_r.vel_y == 32'sh80000000) ? 32'sh7fffffff : -ei_r.vel_y;
        end
        next_move = 1'b1;
      end

      S_CP_RDI: begin
        mem_ra    = i_r[IW-1:0];
        state_nxt = S_CP_RDJ;
      end

      S_CP_RDJ: begin
        mem_ra    = j_r[IW-1:0];
        ei_nxt    = rdata_r;
        state_nxt = S_CP_LD;
      end

      S_CP_LD: begin
        ej_nxt = rdata_r;
        dx_nxt = 27'(dx33);
        dy_nxt = 27'(dy33);
        rq_nxt = rq_w;
        if (dx_mag > 33'(rq_w) || dy_mag > 33'(rq_w)) begin
          next_pair = 1'b1;
        end else begin
          state_nxt = S_CP_RR;
        end
      end

      S_CP_RR: begin
        acc_nxt   = acc_sum;
        state_nxt = S_CP_SQX;
      end

      S_CP_SQX: begin
        rr_nxt    = acc_r[51:0];
        acc_nxt   = acc_sum;
        state_nxt = S_CP_SQY;
      end

      S_CP_SQY: begin
        acc_nxt   = acc_sum;
        state_nxt = S_CP_CMP;
      end

      S_CP_CMP: begin
        if (acc_r[51:0] > rr_r) begin
          next_pair = 1'b1;
        end else begin
          sq_nxt    = acc_r[51:0];
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_CP_SQRT;
        end
      end

      S_CP_SQRT: begin
        sq_nxt   = {sq_r[49:0], 2'b00};
        rem_nxt  = sq_ge ? 28'(sq_rem_sh - 30'(sq_trial)) : 28'(sq_rem_sh);
        root_nxt = {root_r[24:0], sq_ge};
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd25) begin
          dist_nxt  = ({root_r[24:0], sq_ge} == 26'd0) ? MIN_DIST
                                                       : {root_r[24:0], sq_ge};
          dvd_nxt   = {dxm, 16'b0};
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_CP_DIVX;
        end
      end

      S_CP_DIVX: begin
        drem_nxt = dv_ge ? 26'(dv_rem_sh - {1'b0, dist_r}) : 26'(dv_rem_sh);
        dvd_nxt  = dv_q;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd40) begin
          nx_nxt    = dx_r[26] ? -20'(dv_q) : 20'(dv_q);
          dvd_nxt   = {dym, 16'b0};
          drem_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_CP_DIVY;
        end
      end

      S_CP_DIVY: begin
        drem_nxt = dv_ge ? 26'(dv_rem_sh - {1'b0, dist_r}) : 26'(dv_rem_sh);
        dvd_nxt  = dv_q;
        cnt_nxt  = cnt_r + 6'd1;
        if (cnt_r == 6'd40) begin
          ny_nxt    = dy_r[26] ? -20'(dv_q) : 20'(dv_q);
          cnt_nxt   = '0;
          state_nxt = S_CP_MAC;
        end
      end

      S_CP_MAC: begin
        // Each step multiplies once; the step after a sum is complete takes it from the accumulator.
        acc_nxt = acc_sum;
        cnt_nxt = cnt_r + 6'd1;
        case (cnt_r)
          6'd1:  push_x_nxt = 28'(acc_r >>> 17);
          6'd2:  push_y_nxt = 28'(acc_r >>> 17);
          6'd4:  v1t_nxt    = 38'(acc_r >>> 16);
          6'd6:  v2t_nxt    = 38'(acc_r >>> 16);
          6'd8:  v1n_nxt    = 38'(acc_r >>> 16);
          6'd10: v2n_nxt    = 38'(acc_r >>> 16);
          6'd12: nv2x_nxt   = sat32(acc_r >>> 16);
          6'd14: nv2y_nxt   = sat32(acc_r >>> 16);
          6'd16: nv1x_nxt   = sat32(acc_r >>> 16);
          6'd18: nv1y_nxt   = sat32(acc_r >>> 16);
          default: begin
            acc_nxt = acc_sum;
          end
        endcase
        if (cnt_r == 6'd18) begin
          state_nxt = S_CP_WRI;
        end
      end

      S_CP_WRI: begin
        mem_we       = 1'b1;
        mem_wa       = i_r[IW-1:0];
        mem_wd       = ei_r;
        mem_wd.pos_x = sat32(66'(ei_r.pos_x) + 66'(push_x_r));
        mem_wd.pos_y = sat32(66'(ei_r.pos_y) + 66'(push_y_r));
        mem_wd.vel_x = nv1x_r;
        mem_wd.vel_y = nv1y_r;
        state_nxt    = S_CP_WRJ;
      end

      S_CP_WRJ: begin
        mem_we       = 1'b1;
        mem_wa       = j_r[IW-1:0];
        mem_wd       = ej_r;
        mem_wd.pos_x = sat32(66'(ej_r.pos_x) - 66'(push_x_r));
        mem_wd.pos_y = sat32(66'(ej_r.pos_y) - 66'(push_y_r));
        mem_wd.vel_x = nv2x_r;
        mem_wd.vel_y = nv2y_r;
        next_pair    = 1'b1;
      end

      S_EM_RD: begin
        mem_ra    = i_r[IW-1:0];
        state_nxt = S_EM_OUT;
      end

      S_EM_OUT: begin
        out_valid_nxt = 1'b1;
        out_nxt = '{out_index: 5'(i_r), out_pos_x: rdata_r.pos_x,
                    out_pos_y: rdata_r.pos_y, out_vel_x: rdata_r.vel_x,
                    out_vel_y: rdata_r.vel_y, out_life: rdata_r.life,
                    alive: rdata_r.life > 32'sd0,
                    last: (32'(i_r) + 1 == 32'(n_r))};
        i_nxt = i_r + CW'(1);
        if (32'(i_r) + 1 == 32'(n_r)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EM_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Move pass: advance to the next entry, then to the pairs or the emit.
    if (next_move) begin
      if (32'(i_r) + 1 < 32'(n_r)) begin
        i_nxt     = i_r + CW'(1);
        state_nxt = S_MV_RD;
      end else if (32'(n_r) >= 2) begin
        i_nxt     = '0;
        j_nxt     = CW'(1);
        state_nxt = S_CP_RDI;
      end else begin
        i_nxt     = '0;
        state_nxt = S_EM_RD;
      end
    end

    // Pair pass: j runs fastest, pairs visited with i < j in order.
    if (next_pair) begin
      if (32'(j_r) + 1 < 32'(n_r)) begin
        j_nxt     = j_r + CW'(1);
        state_nxt = S_CP_RDI;
      end else if (32'(i_r) + 2 < 32'(n_r)) begin
        i_nxt     = i_r + CW'(1);
        j_nxt     = i_r + CW'(2);
        state_nxt = S_CP_RDI;
      end else begin
        i_nxt     = '0;
        state_nxt = S_EM_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_w_r     <= SCREEN_WIDTH_RST;
      cfg_h_r     <= SCREEN_HEIGHT_RST;
      cfg_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCREEN_WIDTH:   cfg_w_r   <= cfg_wdata;
          CFG_SCREEN_HEIGHT:  cfg_h_r   <= cfg_wdata;
          CFG_PARTICLE_COUNT: cfg_cnt_r <= cfg_wdata[5:0];
          default: begin
            cfg_cnt_r <= cfg_cnt_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    n_r      <= n_nxt;
    dt_r     <= dt_nxt;
    cnt_r    <= cnt_nxt;
    ei_r     <= ei_nxt;
    ej_r     <= ej_nxt;
    acc_r    <= acc_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    rq_r     <= rq_nxt;
    rr_r     <= rr_nxt;
    sq_r     <= sq_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    dist_r   <= dist_nxt;
    drem_r   <= drem_nxt;
    dvd_r    <= dvd_nxt;
    nx_r     <= nx_nxt;
    ny_r     <= ny_nxt;
    push_x_r <= push_x_nxt;
    push_y_r <= push_y_nxt;
    v1t_r    <= v1t_nxt;
    v2t_r    <= v2t_nxt;
    v1n_r    <= v1n_nxt;
    v2n_r    <= v2n_nxt;
    nv1x_r   <= nv1x_nxt;
    nv1y_r   <= nv1y_nxt;
    nv2x_r   <= nv2x_nxt;
    nv2y_r   <= nv2y_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
